FILE: rtl/core/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, codes and helper functions of the capture deadline sequencer.
// ----------------------------------------------------------------------------
package cds_pkg;

  // Command opcodes.
  typedef enum logic [2:0] {
    OP_INIT     = 3'd0,
    OP_START    = 3'd1,
    OP_SERVICE  = 3'd2,
    OP_TAKE     = 3'd3,
    OP_RELEASE  = 3'd4,
    OP_SHUTDOWN = 3'd5
  } opcode_t;

  // Status codes reported with each result item.
  typedef enum logic [3:0] {
    ST_UNINIT  = 4'd0,
    ST_IDLE    = 4'd1,
    ST_PENDING = 4'd2,
    ST_READY   = 4'd3,
    ST_WARMING = 4'd4,
    ST_BUSY    = 4'd5,
    ST_BADCFG  = 4'd6,
    ST_PERM    = 4'd7,
    ST_TIMER   = 4'd8,
    ST_TIMEOUT = 4'd9,
    ST_ADC     = 4'd10,
    ST_OWNER   = 4'd11
  } status_t;

  // Sequencer phase. The fault phases latch the first fault seen.
  typedef enum logic [9:0] {
    PH_UNINIT  = 10'b00_0000_0001,
    PH_IDLE    = 10'b00_0000_0010,
    PH_PENDING = 10'b00_0000_0100,
    PH_READY   = 10'b00_0000_1000,
    PH_BADCFG  = 10'b00_0001_0000,
    PH_PERM    = 10'b00_0010_0000,
    PH_TIMER   = 10'b00_0100_0000,
    PH_TIMEOUT = 10'b00_1000_0000,
    PH_ADC     = 10'b01_0000_0000,
    PH_OWNER   = 10'b10_0000_0000
  } phase_t;

  // ADC answer codes.
  localparam logic [1:0] ADC_WARMING = 2'd0;
  localparam logic [1:0] ADC_PENDING = 2'd1;
  localparam logic [1:0] ADC_READY   = 2'd2;
  localparam logic [1:0] ADC_ERROR   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADLINE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD   = 1'd1;
  localparam int unsigned CFG_DATA_W = 32;

  // Smallest legal deadline, and the spacing treated as a timer wrap.
  localparam logic [31:0] MIN_DEADLINE = 32'd3;
  localparam logic [31:0] WRAP_LIMIT   = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] deadline_limit;
    logic [31:0] trigger_spacing;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_us;
    logic        permitted;
    logic        periph_ok;
    logic [1:0]  adc_code;
    logic        frame_ok;
    logic [15:0] sample_b;
    logic [15:0] sample_c;
    logic [31:0] armed_time;
    logic [31:0] done_time;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        out_valid;
    logic [15:0] out_sample_b;
    logic [15:0] out_sample_c;
    logic [31:0] out_armed_time;
    logic [31:0] out_done_time;
    logic        fire_trigger;
    logic        halt_motor;
    logic        release_ok;
  } res_t;

  // One captured frame as held in the mailbox.
  typedef struct packed {
    logic [15:0] sample_b;
    logic [15:0] sample_c;
    logic [31:0] armed_time;
    logic [31:0] done_time;
  } frame_t;

  // True when the phase holds a latched fault.
  function automatic logic is_faulted(input phase_t ph);
    logic res;
    res = (ph == PH_BADCFG) || (ph == PH_PERM) || (ph == PH_TIMER) ||
          (ph == PH_TIMEOUT) || (ph == PH_ADC) || (ph == PH_OWNER);
    return res;
  endfunction

  // A new fault takes effect only if no fault is latched yet.
  function automatic phase_t fault_phase(input phase_t ph, input phase_t code);
    phase_t res;
    res = is_faulted(ph) ? ph : code;
    return res;
  endfunction

  // Status code that a phase reports.
  function automatic status_t phase_status(input phase_t ph);
    status_t res;
    unique case (ph)
      PH_UNINIT:  res = ST_UNINIT;
      PH_IDLE:    res = ST_IDLE;
      PH_PENDING: res = ST_PENDING;
      PH_READY:   res = ST_READY;
      PH_BADCFG:  res = ST_BADCFG;
      PH_PERM:    res = ST_PERM;
      PH_TIMER:   res = ST_TIMER;
      PH_TIMEOUT: res = ST_TIMEOUT;
      PH_ADC:     res = ST_ADC;
      PH_OWNER:   res = ST_OWNER;
      default:    res = ST_UNINIT;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/cds_if.sv
// ----------------------------------------------------------------------------
// cds_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface cds_cmd_if;
  logic          valid;
  logic          ready;
  cds_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cds_res_if;
  logic          valid;
  logic          ready;
  cds_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/capture_deadline_sequencer.sv
// ----------------------------------------------------------------------------
// capture_deadline_sequencer
// Sequencer for triggered current-sample capture with deadline, trigger
// spacing, fault latch and a one-frame mailbox.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Carries
//   cmd       in         valid/ready        one command item
//   res       out        valid/ready        one result item per command
//   cfg       in         cfg_we, no wait    deadline limit (0), trigger spacing (1)
//
// An accepted item sits in the command register, is decided and lands in the
// result register when the engine takes it; one item per cycle is sustained
// while each result is taken as it appears. The rate is set by the single
// decision stage between the command register and the result register.
// Reset clears the phase, the time stamps, the flags and the valid flags of both registers.
// When the result is not taken, the command register holds one more item
// and cmd.ready then falls until the result leaves.
// ----------------------------------------------------------------------------
module capture_deadline_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  cds_cmd_if.sink                          cmd,
  cds_res_if.source                        res,
  input  logic                             cfg_we,
  input  logic [cds_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cds_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cds_pkg::cfg_t cfg;
  logic          cmd_valid;
  cds_pkg::cmd_t cmd_data;
  logic          take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadline_limit  <= 32'd0;
      cfg.trigger_spacing <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cds_pkg::REG_DEADLINE: cfg.deadline_limit  <= cfg_data;
        cds_pkg::REG_PERIOD:   cfg.trigger_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command register.
  cds_cmd_reg u_cmd_reg (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .take      (take),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data)
  );

  // Decision logic, sequencer state and result register.
  cds_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .take      (take),
    .res       (res)
  );

endmodule

FILE: rtl/core/cds_cmd_reg.sv
// ----------------------------------------------------------------------------
// cds_cmd_reg
// Input register: captures one command item and holds it until the engine
// takes it.
// ----------------------------------------------------------------------------
module cds_cmd_reg (
  input  logic                clk,
  input  logic                rst,
  cds_cmd_if.sink             cmd,
  input  logic                take,
  output logic                cmd_valid,
  output cds_pkg::cmd_t       cmd_data
);

  logic full;

  // A new item may enter when the register is empty or is emptied this cycle.
  assign cmd.ready = !full || take;
  assign cmd_valid = full;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (cmd.ready) begin
      full <= cmd.valid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_data <= cmd.payload;
    end
  end

endmodule

FILE: rtl/core/cds_engine.sv
// ----------------------------------------------------------------------------
// cds_engine
// Sequencer state, the per-command decision logic and the result register.
// ----------------------------------------------------------------------------
module cds_engine (
  input  logic                clk,
  input  logic                rst,
  input  cds_pkg::cfg_t       cfg,
  input  logic                cmd_valid,
  input  cds_pkg::cmd_t       cmd_data,
  output logic                take,
  cds_res_if.source           res
);

  // Sequencer state.
  cds_pkg::phase_t  phase, phase_next;
  logic [31:0]      start_time, start_time_next;
  logic [31:0]      last_trigger_time, last_trigger_time_next;
  logic             has_triggered, has_triggered_next;
  logic             timers_held, timers_held_next;
  logic             adc_held, adc_held_next;
  logic             mail_full, mail_full_next;
  cds_pkg::frame_t  mail_frame, mail_frame_next;

  // Result register.
  logic             res_valid;
  cds_pkg::res_t    res_data, res_data_next;

  // Decision terms.
  logic [31:0]      elapsed_trig;
  logic [31:0]      elapsed_start;
  logic             bad_cfg;
  cds_pkg::status_t status;
  logic             inhibit;
  logic             fire;
  logic             rel_ok;
  logic             deliver;

  // An item moves on when the result register is free or being emptied.
  assign take      = cmd_valid && (!res_valid || res.ready);
  assign res.valid = res_valid;
  assign res.payload = res_data;

  assign elapsed_trig  = cmd_data.now_us - last_trigger_time;
  assign elapsed_start = cmd_data.now_us - start_time;
  assign bad_cfg = (cfg.deadline_limit < cds_pkg::MIN_DEADLINE) ||
                   (cfg.trigger_spacing >= cds_pkg::WRAP_LIMIT) ||
                   (({1'b0, cfg.deadline_limit} + 33'd1) >= {1'b0, cfg.trigger_spacing});

  // Command decision: next state and result fields.
  always_comb begin
    phase_next             = phase;
    start_time_next        = start_time;
    last_trigger_time_next = last_trigger_time;
    has_triggered_next     = has_triggered;
    timers_held_next       = timers_held;
    adc_held_next          = adc_held;
    mail_full_next         = mail_full;
    mail_frame_next        = mail_frame;
    status                 = cds_pkg::phase_status(phase);
    inhibit                = 1'b0;
    fire                   = 1'b0;
    rel_ok                 = 1'b0;
    deliver                = 1'b0;

    // Service of a pending capture, shared by service and take.
    if (((cmd_data.opcode == cds_pkg::OP_SERVICE) || (cmd_data.opcode == cds_pkg::OP_TAKE)) &&
        (phase == cds_pkg::PH_PENDING)) begin
      if (!cmd_data.permitted) begin
        phase_next = cds_pkg::PH_PERM;
        mail_full_next = 1'b0;
        inhibit = 1'b1;
      end else if (!cmd_data.periph_ok) begin
        phase_next = cds_pkg::PH_TIMER;
        mail_full_next = 1'b0;
        inhibit = 1'b1;
      end else if (elapsed_start > cfg.deadline_limit) begin
        phase_next = cds_pkg::PH_TIMEOUT;
        mail_full_next = 1'b0;
        inhibit = 1'b1;
      end else if (cmd_data.adc_code == cds_pkg::ADC_PENDING) begin
        phase_next = phase;
      end else if ((cmd_data.adc_code != cds_pkg::ADC_READY) || !cmd_data.frame_ok) begin
        phase_next = cds_pkg::PH_ADC;
        mail_full_next = 1'b0;
        inhibit = 1'b1;
      end else begin
        mail_frame_next.sample_b   = cmd_data.sample_b;
        mail_frame_next.sample_c   = cmd_data.sample_c;
        mail_frame_next.armed_time = cmd_data.armed_time;
        mail_frame_next.done_time  = cmd_data.done_time;
        mail_full_next = 1'b1;
        phase_next = cds_pkg::PH_READY;
      end
    end

    case (cmd_data.opcode)
      cds_pkg::OP_INIT: begin
        if (phase != cds_pkg::PH_UNINIT) begin
          status = cds_pkg::ST_BUSY;
        end else if (bad_cfg) begin
          phase_next = cds_pkg::PH_BADCFG;
          mail_full_next = 1'b0;
          inhibit = 1'b1;
          status = cds_pkg::ST_BADCFG;
        end else begin
          if (!cmd_data.permitted) begin
            phase_next = cds_pkg::PH_PERM;
            mail_full_next = 1'b0;
            inhibit = 1'b1;
          end else if (!cmd_data.periph_ok) begin
            phase_next = cds_pkg::PH_OWNER;
            mail_full_next = 1'b0;
            inhibit = 1'b1;
          end else begin
            timers_held_next = 1'b1;
            if (cmd_data.adc_code != cds_pkg::ADC_WARMING) begin
              phase_next = cds_pkg::PH_ADC;
              mail_full_next = 1'b0;
              inhibit = 1'b1;
            end else begin
              adc_held_next = 1'b1;
              has_triggered_next = 1'b0;
              mail_full_next = 1'b0;
              phase_next = cds_pkg::PH_IDLE;
            end
          end
          status = cds_pkg::phase_status(phase_next);
        end
      end
      cds_pkg::OP_START: begin
        if ((phase == cds_pkg::PH_UNINIT) || cds_pkg::is_faulted(phase)) begin
          status = cds_pkg::phase_status(phase);
        end else if (phase != cds_pkg::PH_IDLE) begin
          status = cds_pkg::ST_BUSY;
        end else if (!cmd_data.permitted) begin
          phase_next = cds_pkg::PH_PERM;
          mail_full_next = 1'b0;
          inhibit = 1'b1;
          status = cds_pkg::ST_PERM;
        end else if (!cmd_data.periph_ok) begin
          phase_next = cds_pkg::PH_TIMER;
          mail_full_next = 1'b0;
          inhibit = 1'b1;
          status = cds_pkg::ST_TIMER;
        end else if (has_triggered && (elapsed_trig >= cds_pkg::WRAP_LIMIT)) begin
          // Spacing this large means the time base wrapped past the last trigger.
          phase_next = cds_pkg::PH_TIMEOUT;
          mail_full_next = 1'b0;
          inhibit = 1'b1;
          status = cds_pkg::ST_TIMEOUT;
        end else if (has_triggered && (elapsed_trig < cfg.trigger_spacing)) begin
          status = cds_pkg::ST_BUSY;
        end else begin
          start_time_next = cmd_data.now_us;
          if (cmd_data.adc_code == cds_pkg::ADC_WARMING) begin
            status = cds_pkg::ST_WARMING;
          end else if (cmd_data.adc_code != cds_pkg::ADC_PENDING) begin
            phase_next = cds_pkg::PH_ADC;
            mail_full_next = 1'b0;
            inhibit = 1'b1;
            status = cds_pkg::ST_ADC;
          end else begin
            phase_next = cds_pkg::PH_PENDING;
            fire = 1'b1;
            last_trigger_time_next = cmd_data.now_us;
            has_triggered_next = 1'b1;
            status = cds_pkg::ST_PENDING;
          end
        end
      end
      cds_pkg::OP_SERVICE: begin
        status = cds_pkg::phase_status(phase_next);
      end
      cds_pkg::OP_TAKE: begin
        if (phase_next == cds_pkg::PH_READY) begin
          if (!cmd_data.permitted) begin
            phase_next = cds_pkg::PH_PERM;
            mail_full_next = 1'b0;
            inhibit = 1'b1;
          end else if (!cmd_data.periph_ok) begin
            phase_next = cds_pkg::PH_TIMER;
            mail_full_next = 1'b0;
            inhibit = 1'b1;
          end else begin
            deliver = mail_full_next;
            mail_full_next = 1'b0;
            phase_next = cds_pkg::PH_IDLE;
          end
        end
        status = deliver || (phase_next == cds_pkg::PH_IDLE && phase_next != phase) ?
                 cds_pkg::ST_READY : cds_pkg::phase_status(phase_next);
      end
      cds_pkg::OP_RELEASE: begin
        if ((phase != cds_pkg::PH_IDLE) || !timers_held || !adc_held || mail_full) begin
          phase_next = cds_pkg::fault_phase(phase, cds_pkg::PH_OWNER);
          mail_full_next = 1'b0;
          inhibit = 1'b1;
        end else if (!cmd_data.permitted) begin
          phase_next = cds_pkg::PH_PERM;
          mail_full_next = 1'b0;
          inhibit = 1'b1;
        end else if (!cmd_data.periph_ok) begin
          phase_next = cds_pkg::PH_TIMER;
          mail_full_next = 1'b0;
          inhibit = 1'b1;
        end else begin
          timers_held_next = 1'b0;
          adc_held_next = 1'b0;
          has_triggered_next = 1'b0;
          mail_full_next = 1'b0;
          phase_next = cds_pkg::PH_UNINIT;
          rel_ok = 1'b1;
        end
        status = cds_pkg::phase_status(phase_next);
      end
      cds_pkg::OP_SHUTDOWN: begin
        inhibit = 1'b1;
        timers_held_next = 1'b0;
        adc_held_next = 1'b0;
        has_triggered_next = 1'b0;
        mail_full_next = 1'b0;
        phase_next = cds_pkg::PH_UNINIT;
        status = cds_pkg::ST_UNINIT;
      end
      default: begin
        // Unknown opcodes report the phase and change nothing.
        status = cds_pkg::phase_status(phase);
      end
    endcase
  end

  // Result fields; the frame reads as zero unless a take delivers it.
  always_comb begin
    res_data_next.status         = status;
    res_data_next.out_valid      = deliver;
    res_data_next.out_sample_b   = deliver ? mail_frame_next.sample_b : 16'd0;
    res_data_next.out_sample_c   = deliver ? mail_frame_next.sample_c : 16'd0;
    res_data_next.out_armed_time = deliver ? mail_frame_next.armed_time : 32'd0;
    res_data_next.out_done_time  = deliver ? mail_frame_next.done_time : 32'd0;
    res_data_next.fire_trigger   = fire;
    res_data_next.halt_motor     = inhibit;
    res_data_next.release_ok     = rel_ok;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= cds_pkg::PH_UNINIT;
      start_time    <= 32'd0;
      last_trigger_time <= 32'd0;
      has_triggered <= 1'b0;
      timers_held   <= 1'b0;
      adc_held      <= 1'b0;
      mail_full     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        start_time    <= start_time_next;
        last_trigger_time <= last_trigger_time_next;
        has_triggered <= has_triggered_next;
        timers_held   <= timers_held_next;
        adc_held      <= adc_held_next;
        mail_full     <= mail_full_next;
      end
      if (take) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Mailbox frame and result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      mail_frame <= mail_frame_next;
      res_data   <= res_data_next;
    end
  end

endmodule
